@@ rtl/mlr_pkg.sv @@
// Shared types, codes and tables of the mosaic layout rectangles block.
// Used by every module in rtl/; depends on nothing.
package mlr_pkg;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_LAYOUT_CODE  = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SMALL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    LAYOUT_1  = 4'd0,
    LAYOUT_2  = 4'd1,
    LAYOUT_3  = 4'd2,
    LAYOUT_4  = 4'd3,
    LAYOUT_6  = 4'd4,
    LAYOUT_8  = 4'd5,
    LAYOUT_9  = 4'd6,
    LAYOUT_13 = 4'd7,
    LAYOUT_16 = 4'd8,
    LAYOUT_25 = 4'd9
  } layout_e;

  localparam int unsigned DimW   = 14;
  localparam int unsigned UnitsW = DimW - 3;  // dimension in 8-pixel units
  localparam int unsigned QuotW  = UnitsW - 1;  // strip size in units, at least 2 strips

  // Tile placement in strips.
  typedef struct packed {
    logic [2:0] col;
    logic [2:0] row;
    logic [2:0] cspan;
    logic [2:0] rspan;
  } place_t;

  typedef struct packed {
    logic [2:0] strips;
    logic [4:0] count;
    logic [4:0] base;
    logic       tabled;
    logic       single;
    logic       defined;
  } layout_t;

  // Decoded query, handed from the decoder to the pipeline.
  typedef struct packed {
    place_t     place;
    logic [2:0] strips;
    logic       single;
    logic       bad_code;
    logic       over;
  } decode_t;

  // Irregular layouts: nibbles are col, row, col span, row span.
  localparam logic [15:0] PLACE_TAB [32] = '{
    16'h0122, 16'h2122,
    16'h1022, 16'h0222, 16'h2222,
    16'h0022, 16'h2011, 16'h2111, 16'h0211, 16'h1211, 16'h2211,
    16'h0033, 16'h3011, 16'h3111, 16'h3211,
    16'h0311, 16'h1311, 16'h2311, 16'h3311,
    16'h0011, 16'h1011, 16'h2011, 16'h3011,
    16'h0111, 16'h1122, 16'h3111,
    16'h0211, 16'h3211,
    16'h0311, 16'h1311, 16'h2311, 16'h3311
  };

  function automatic place_t place_lookup(input logic [4:0] idx);
    logic [15:0] e;
    e = PLACE_TAB[idx];
    return '{col: e[14:12], row: e[10:8], cspan: e[6:4], rspan: e[2:0]};
  endfunction

  function automatic layout_t layout_info(input logic [3:0] code);
    layout_t l;
    l = '{strips: 3'd1, count: 5'd0, base: 5'd0, tabled: 1'b0, single: 1'b0, defined: 1'b0};
    case (layout_e'(code))
      LAYOUT_1:  l = '{3'd1, 5'd1,  5'd0,  1'b0, 1'b1, 1'b1};
      LAYOUT_2:  l = '{3'd4, 5'd2,  5'd0,  1'b1, 1'b0, 1'b1};
      LAYOUT_3:  l = '{3'd4, 5'd3,  5'd2,  1'b1, 1'b0, 1'b1};
      LAYOUT_4:  l = '{3'd2, 5'd4,  5'd0,  1'b0, 1'b0, 1'b1};
      LAYOUT_6:  l = '{3'd3, 5'd6,  5'd5,  1'b1, 1'b0, 1'b1};
      LAYOUT_8:  l = '{3'd4, 5'd8,  5'd11, 1'b1, 1'b0, 1'b1};
      LAYOUT_9:  l = '{3'd3, 5'd9,  5'd0,  1'b0, 1'b0, 1'b1};
      LAYOUT_13: l = '{3'd4, 5'd13, 5'd19, 1'b1, 1'b0, 1'b1};
      LAYOUT_16: l = '{3'd4, 5'd16, 5'd0,  1'b0, 1'b0, 1'b1};
      LAYOUT_25: l = '{3'd5, 5'd25, 5'd0,  1'b0, 1'b0, 1'b1};
      default:   l = '{3'd1, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0};
    endcase
    return l;
  endfunction

endpackage

@@ rtl/mlr_decode.sv @@
// Query decoder: layout code and tile index to strip placement and flags.
// Depends on mlr_pkg.
module mlr_decode (
  input  logic [3:0]       layout_code_i,
  input  logic [4:0]       tile_index_i,
  output mlr_pkg::decode_t dec_o
);

  mlr_pkg::layout_t lay;
  mlr_pkg::place_t  tab_place;
  logic [2:0]       grid_row;
  logic [4:0]       row_base;
  logic [4:0]       grid_col;

  always_comb begin
    lay       = mlr_pkg::layout_info(layout_code_i);
    tab_place = mlr_pkg::place_lookup(lay.base + tile_index_i);

    // Row of a regular grid: count the row starts at or below the index.
    grid_row = 3'd0;
    for (int k = 1; k < 5; k++) begin
      if ((k < int'(lay.strips)) && (int'(tile_index_i) >= k * int'(lay.strips))) begin
        grid_row = grid_row + 3'd1;
      end
    end
    row_base = 5'(grid_row * lay.strips);
    grid_col = tile_index_i - row_base;

    if (lay.tabled) begin
      dec_o.place = tab_place;
    end else begin
      dec_o.place = '{col: grid_col[2:0], row: grid_row, cspan: 3'd1, rspan: 3'd1};
    end
    dec_o.strips   = lay.strips;
    dec_o.single   = lay.single;
    dec_o.bad_code = !lay.defined;
    dec_o.over     = (tile_index_i >= lay.count);
  end

endmodule

@@ rtl/mlr_quot.sv @@
// Strip size of one dimension: units divided by 2..5, by shift or reciprocal.
// Depends on mlr_pkg.
module mlr_quot (
  input  logic [mlr_pkg::UnitsW-1:0] units_i,
  input  logic [2:0]                 strips_i,
  output logic [mlr_pkg::QuotW-1:0]  quot_o
);

  // 2731 / 2^13 and 1639 / 2^13 are exact floors for units below 2^11.
  logic [23:0] prod3;
  logic [21:0] prod5;

  assign prod3 = {13'd0, units_i} * 24'd2731;
  assign prod5 = {11'd0, units_i} * 22'd1639;

  always_comb begin
    case (strips_i)
      3'd2:    quot_o = units_i[10:1];
      3'd3:    quot_o = prod3[22:13];
      3'd4:    quot_o = {1'b0, units_i[10:2]};
      3'd5:    quot_o = {1'b0, prod5[21:13]};
      default: quot_o = units_i[9:0];
    endcase
  end

endmodule

@@ rtl/mlr_strip.sv @@
// Offset and size of a run of strips in one dimension, in pixels.
// Depends on mlr_pkg.
module mlr_strip (
  input  logic [12:0]              pos_mul_i,   // pos * strip size
  input  logic [12:0]              span_mul_i,  // span * strip size
  input  logic [2:0]               pos_i,
  input  logic [2:0]               span_i,
  input  logic [2:0]               rem_i,
  output logic [mlr_pkg::DimW-1:0] offset_o,
  output logic [mlr_pkg::DimW-1:0] size_o
);

  logic [3:0]  run_end;
  logic [3:0]  lim;
  logic [2:0]  extra_pos;
  logic [2:0]  extra_span;
  logic [12:0] off_units;
  logic [12:0] size_units;

  always_comb begin
    // The first rem strips carry one extra unit each.
    extra_pos  = (pos_i < rem_i) ? pos_i : rem_i;
    run_end    = {1'b0, pos_i} + {1'b0, span_i};
    lim        = (run_end < {1'b0, rem_i}) ? run_end : {1'b0, rem_i};
    extra_span = (lim > {1'b0, pos_i}) ? 3'(lim - {1'b0, pos_i}) : 3'd0;
    off_units  = pos_mul_i + {10'd0, extra_pos};
    size_units = span_mul_i + {10'd0, extra_span};
    offset_o   = {off_units[10:0], 3'b000};
    size_o     = {size_units[10:0], 3'b000};
  end

endmodule

@@ rtl/mosaic_layout_rectangles.sv @@
// Top level of the mosaic layout rectangles block: config registers and pipeline.
// Depends on mlr_pkg, mlr_decode, mlr_quot and mlr_strip.
//
// Answers one tile query per clock: for a tile index it returns the tile's left and
// top offsets, width and height in pixels, plus a status (ok, index beyond the
// layout's tile count or undefined layout code, or frame dimension too small to
// split). Each dimension is cut into 2 to 5 strips that are multiples of 8 pixels,
// the remainder spread over the first strips; the single-tile layout returns the
// whole frame unrounded. A query passes three register stages before tvalid rises
// on the result side. Stage 1 decodes the layout and divides the dimensions by the
// strip count, stage 2 forms the remainders, the strip products and the status,
// stage 3 adds the extra units and registers the result. The pipeline takes a new
// query every cycle; a stalled result side holds each stage in place. Frame size
// and layout code are written through the cfg port, which is always ready; write it
// only while no query is in flight.
module mosaic_layout_rectangles (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  // query side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [4:0] tile_index, [7:5] zero
  // result side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [13:0] left_offset, [27:14] top_offset,
                                        // [41:28] tile_width, [55:42] tile_height
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  // ---------------------------------------------------------------- config
  logic [13:0] frame_width_q;
  logic [13:0] frame_height_q;
  logic [3:0]  layout_code_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 14'd1920;
      frame_height_q <= 14'd1080;
      layout_code_q  <= 4'd0;
    end else if (cfg_valid_i) begin
      case (mlr_pkg::cfg_index_e'(cfg_index_i))
        mlr_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        mlr_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        mlr_pkg::REG_LAYOUT_CODE:  layout_code_q  <= cfg_data_i[3:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  logic [mlr_pkg::UnitsW-1:0] units_w;
  logic [mlr_pkg::UnitsW-1:0] units_h;
  assign units_w = frame_width_q[13:3];
  assign units_h = frame_height_q[13:3];

  // ---------------------------------------------------------------- flow control
  // A stage advances when it is empty or the stage after it advances.
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3            = !v3_q || m_axis_tready_i;
  assign adv2            = !v2_q || adv3;
  assign adv1            = !v1_q || adv2;
  assign s_axis_tready_o = adv1;
  assign m_axis_tvalid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Decode the query and divide both dimensions by the strip count.
  mlr_pkg::decode_t           dec_d, dec1_q;
  logic [mlr_pkg::QuotW-1:0]  qw_d, qh_d, qw1_q, qh1_q;

  mlr_decode u_decode (
    .layout_code_i (layout_code_q),
    .tile_index_i  (s_axis_tdata_i[4:0]),
    .dec_o         (dec_d)
  );

  mlr_quot u_quot_w (.units_i(units_w), .strips_i(dec_d.strips), .quot_o(qw_d));
  mlr_quot u_quot_h (.units_i(units_h), .strips_i(dec_d.strips), .quot_o(qh_d));

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      dec1_q <= dec_d;
      qw1_q  <= qw_d;
      qh1_q  <= qh_d;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Remainders, strip products and the final status.
  logic [12:0] qnw, qnh;
  logic [2:0]  rw_d, rh_d;
  logic [12:0] lmul_d, wmul_d, tmul_d, hmul_d;
  logic [1:0]  status_d;

  logic [2:0]  rw2_q, rh2_q;
  logic [12:0] lmul2_q, wmul2_q, tmul2_q, hmul2_q;
  logic [1:0]  status2_q;
  logic        single2_q;
  mlr_pkg::place_t place2_q;

  always_comb begin
    qnw    = {3'd0, qw1_q} * {10'd0, dec1_q.strips};
    qnh    = {3'd0, qh1_q} * {10'd0, dec1_q.strips};
    rw_d   = 3'(units_w - qnw[10:0]);
    rh_d   = 3'(units_h - qnh[10:0]);
    lmul_d = {10'd0, dec1_q.place.col}   * {3'd0, qw1_q};
    wmul_d = {10'd0, dec1_q.place.cspan} * {3'd0, qw1_q};
    tmul_d = {10'd0, dec1_q.place.row}   * {3'd0, qh1_q};
    hmul_d = {10'd0, dec1_q.place.rspan} * {3'd0, qh1_q};

    // Bad code first, then the single tile, then too small before out of range.
    if (dec1_q.bad_code) begin
      status_d = mlr_pkg::ST_RANGE;
    end else if (dec1_q.single) begin
      status_d = dec1_q.over ? mlr_pkg::ST_RANGE : mlr_pkg::ST_OK;
    end else if (qw1_q == '0 || qh1_q == '0) begin
      status_d = mlr_pkg::ST_SMALL;
    end else if (dec1_q.over) begin
      status_d = mlr_pkg::ST_RANGE;
    end else begin
      status_d = mlr_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      rw2_q     <= rw_d;
      rh2_q     <= rh_d;
      lmul2_q   <= lmul_d;
      wmul2_q   <= wmul_d;
      tmul2_q   <= tmul_d;
      hmul2_q   <= hmul_d;
      status2_q <= status_d;
      single2_q <= dec1_q.single;
      place2_q  <= dec1_q.place;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Add the extra units of the leading strips and register the result.
  logic [13:0] left_d, width_d, top_d, height_d;
  logic [55:0] tdata_d, tdata_q;
  logic [1:0]  tuser_q;

  mlr_strip u_strip_w (
    .pos_mul_i  (lmul2_q),
    .span_mul_i (wmul2_q),
    .pos_i      (place2_q.col),
    .span_i     (place2_q.cspan),
    .rem_i      (rw2_q),
    .offset_o   (left_d),
    .size_o     (width_d)
  );

  mlr_strip u_strip_h (
    .pos_mul_i  (tmul2_q),
    .span_mul_i (hmul2_q),
    .pos_i      (place2_q.row),
    .span_i     (place2_q.rspan),
    .rem_i      (rh2_q),
    .offset_o   (top_d),
    .size_o     (height_d)
  );

  always_comb begin
    if (status2_q != mlr_pkg::ST_OK) begin
      tdata_d = '0;
    end else if (single2_q) begin
      // whole frame, no rounding to 8
      tdata_d = {frame_height_q, frame_width_q, 14'd0, 14'd0};
    end else begin
      tdata_d = {height_d, width_d, top_d, left_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      tdata_q <= tdata_d;
      tuser_q <= status2_q;
    end
  end

  assign m_axis_tdata_o = tdata_q;
  assign m_axis_tuser_o = tuser_q;

  // ---------------------------------------------------------------- checks
  a_err_zero_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != mlr_pkg::ST_OK) |-> (m_axis_tdata_o == '0))
    else $error("nonzero status with nonzero rectangle");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3))
    else $error("undefined status code");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && v3_q && !m_axis_tready_i) |=> (v2_q && $stable(status2_q)))
    else $error("middle stage lost its item under stall");

  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("query taken while the pipeline is full and stalled");

endmodule

@@ verif/mosaic_layout_rectangles_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of mosaic_layout_rectangles: directed rows, then random tile queries.
// Depends on mlr_pkg and the RTL top; predicts each rectangle on its own and checks it in order.
module mosaic_layout_rectangles_tb;

  // Expected answer to one tile query.
  typedef struct packed {
    logic [13:0]      left;
    logic [13:0]      top;
    logic [13:0]      width;
    logic [13:0]      height;
    mlr_pkg::status_e status;
  } rect_t;

  typedef enum logic {ROW_CFG, ROW_QUERY} row_kind_e;

  // One row of the directed part: a register write or a query with an optional fixed answer.
  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [13:0] data;
    logic [4:0]  tile;
    logic        fixed;
    rect_t       want;
  } stim_row_t;

  typedef enum logic [1:0] {RDY_OPEN, RDY_RANDOM, RDY_PATTERN, RDY_HOLD} rdy_mode_e;

  localparam logic [1:0] REG_SPARE  = 2'd3;  // unmapped index, the block must ignore it
  localparam int         IDLE_LIMIT = 2000;
  localparam int         RAND_ITEMS = 1700;
  localparam int         DRAIN      = 8;
  localparam int         DIR_ROWS   = 35;

  localparam rect_t RECT_RANGE = '{14'd0, 14'd0, 14'd0, 14'd0, mlr_pkg::ST_RANGE};
  localparam rect_t RECT_SMALL = '{14'd0, 14'd0, 14'd0, 14'd0, mlr_pkg::ST_SMALL};
  localparam rect_t RECT_NONE  = '{14'd0, 14'd0, 14'd0, 14'd0, mlr_pkg::ST_OK};

  // Directed part: reset values, index limits, the too-small and undefined-code cases,
  // the single tile on an empty frame and the extremes of the frame size.
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd0, 1'b1, '{14'd0, 14'd0, 14'd1920, 14'd1080, mlr_pkg::ST_OK}},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd1, 1'b1, RECT_RANGE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd31, 1'b1, RECT_RANGE},
    '{ROW_CFG, mlr_pkg::REG_LAYOUT_CODE, 14'(mlr_pkg::LAYOUT_25), 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd24, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd25, 1'b1, RECT_RANGE},
    '{ROW_CFG, mlr_pkg::REG_FRAME_WIDTH, 14'd8192, 5'd0, 1'b0, RECT_NONE},
    '{ROW_CFG, mlr_pkg::REG_FRAME_HEIGHT, 14'h3FFF, 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd12, 1'b0, RECT_NONE},
    '{ROW_CFG, mlr_pkg::REG_FRAME_WIDTH, 14'd39, 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd0, 1'b1, RECT_SMALL},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd31, 1'b1, RECT_SMALL},
    '{ROW_CFG, mlr_pkg::REG_FRAME_WIDTH, 14'd40, 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd4, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd20, 1'b0, RECT_NONE},
    '{ROW_CFG, mlr_pkg::REG_LAYOUT_CODE, 14'h3FFF, 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd0, 1'b1, RECT_RANGE},
    '{ROW_CFG, mlr_pkg::REG_LAYOUT_CODE, 14'(mlr_pkg::LAYOUT_1), 5'd0, 1'b0, RECT_NONE},
    '{ROW_CFG, mlr_pkg::REG_FRAME_WIDTH, 14'd0, 5'd0, 1'b0, RECT_NONE},
    '{ROW_CFG, mlr_pkg::REG_FRAME_HEIGHT, 14'd0, 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd0, 1'b1, RECT_NONE},
    '{ROW_CFG, REG_SPARE, 14'h3FFF, 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd0, 1'b1, RECT_NONE},
    '{ROW_CFG, mlr_pkg::REG_LAYOUT_CODE, 14'(mlr_pkg::LAYOUT_13), 5'd0, 1'b0, RECT_NONE},
    '{ROW_CFG, mlr_pkg::REG_FRAME_WIDTH, 14'd1920, 5'd0, 1'b0, RECT_NONE},
    '{ROW_CFG, mlr_pkg::REG_FRAME_HEIGHT, 14'd1080, 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd5, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd12, 1'b0, RECT_NONE},
    '{ROW_CFG, mlr_pkg::REG_LAYOUT_CODE, 14'(mlr_pkg::LAYOUT_8), 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd7, 1'b0, RECT_NONE},
    '{ROW_CFG, mlr_pkg::REG_LAYOUT_CODE, 14'(mlr_pkg::LAYOUT_6), 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd0, 1'b0, RECT_NONE},
    '{ROW_QUERY, REG_SPARE, 14'd0, 5'd5, 1'b0, RECT_NONE}
  };

  // DUT ports; every input holds a known value from time zero.
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i     = mlr_pkg::REG_FRAME_WIDTH;
  logic [13:0] cfg_data_i      = 14'd0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'd0;   // [4:0] tile_index, [7:5] zero
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;           // [13:0] left, [27:14] top, [41:28] width, [55:42] height
  logic [1:0]  m_axis_tuser_o;           // [1:0] status

  // Shadow of the configuration registers, updated when a write is accepted.
  logic [13:0] cur_width  = 14'd1920;
  logic [13:0] cur_height = 14'd1080;
  logic [3:0]  cur_layout = 4'(mlr_pkg::LAYOUT_1);

  rect_t pending_rects [$];   // rectangles owed by the block, oldest first
  int    mismatch_cnt = 0;
  int    idle_cnt     = 0;
  int    burst_left   = 40;
  int    sent_cnt     = 0;

  // Receiver stall pattern state.
  rdy_mode_e rdy_mode = RDY_OPEN;
  int        rdy_left = 0;
  int        pat_period = 2;
  int        pat_cnt = 0;

  mosaic_layout_rectangles dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Number of tiles of a layout code; zero for undefined codes.
  function automatic int tile_count(input logic [3:0] code);
    case (mlr_pkg::layout_e'(code))
      mlr_pkg::LAYOUT_1:  return 1;
      mlr_pkg::LAYOUT_2:  return 2;
      mlr_pkg::LAYOUT_3:  return 3;
      mlr_pkg::LAYOUT_4:  return 4;
      mlr_pkg::LAYOUT_6:  return 6;
      mlr_pkg::LAYOUT_8:  return 8;
      mlr_pkg::LAYOUT_9:  return 9;
      mlr_pkg::LAYOUT_13: return 13;
      mlr_pkg::LAYOUT_16: return 16;
      mlr_pkg::LAYOUT_25: return 25;
      default:            return 0;
    endcase
  endfunction

  // Pixels covered by strips first .. first+cnt-1 when dim is cut into n strips of 8-pixel units.
  function automatic logic [13:0] strip_span(input logic [13:0] dim, input int n, input int first,
                                             input int cnt);
    int units, q, r, s, i;
    units = int'(dim >> 3);
    q = units / n;
    r = units % n;
    s = 0;
    for (i = first; i < first + cnt && i < n; i++)
      s += (q + ((i < r) ? 1 : 0)) * 8;
    return s[13:0];
  endfunction

  // Rectangle of one tile under the current shadow configuration.
  function automatic rect_t tile_rect(input logic [4:0] tile);
    rect_t res;
    int    t, n, col, row, cs, rs;
    res = RECT_NONE;
    t = int'(tile);
    n = 1;
    case (mlr_pkg::layout_e'(cur_layout))
      mlr_pkg::LAYOUT_4:                    n = 2;
      mlr_pkg::LAYOUT_6, mlr_pkg::LAYOUT_9: n = 3;
      mlr_pkg::LAYOUT_25:                   n = 5;
      mlr_pkg::LAYOUT_1:                    n = 1;
      default:                              n = 4;
    endcase
    if (tile_count(cur_layout) == 0) begin
      res.status = mlr_pkg::ST_RANGE;
    end else if (mlr_pkg::layout_e'(cur_layout) == mlr_pkg::LAYOUT_1) begin
      // single tile: the whole frame, not rounded to 8
      if (t != 0) begin
        res.status = mlr_pkg::ST_RANGE;
      end else begin
        res.width  = cur_width;
        res.height = cur_height;
      end
    end else if ((int'(cur_width >> 3) / n) == 0 || (int'(cur_height >> 3) / n) == 0) begin
      res.status = mlr_pkg::ST_SMALL;   // checked ahead of the index
    end else if (t >= tile_count(cur_layout)) begin
      res.status = mlr_pkg::ST_RANGE;
    end else begin
      // regular grid by default, fixed groupings for the irregular layouts
      col = t % n;
      row = t / n;
      cs = 1;
      rs = 1;
      case (mlr_pkg::layout_e'(cur_layout))
        mlr_pkg::LAYOUT_2: begin
          col = 2 * t; row = 1; cs = 2; rs = 2;
        end
        mlr_pkg::LAYOUT_3: begin
          cs = 2; rs = 2;
          if (t == 0) begin
            col = 1; row = 0;
          end else begin
            col = 2 * (t - 1); row = 2;
          end
        end
        mlr_pkg::LAYOUT_6: begin
          if (t == 0) begin
            col = 0; row = 0; cs = 2; rs = 2;
          end else if (t < 3) begin
            col = 2; row = t - 1;
          end else begin
            col = t - 3; row = 2;
          end
        end
        mlr_pkg::LAYOUT_8: begin
          if (t == 0) begin
            col = 0; row = 0; cs = 3; rs = 3;
          end else if (t < 4) begin
            col = 3; row = t - 1;
          end else begin
            col = t - 4; row = 3;
          end
        end
        mlr_pkg::LAYOUT_13: begin
          if (t < 4) begin
            col = t; row = 0;
          end else if (t == 4) begin
            col = 0; row = 1;
          end else if (t == 5) begin
            col = 1; row = 1; cs = 2; rs = 2;
          end else if (t == 6) begin
            col = 3; row = 1;
          end else if (t == 7) begin
            col = 0; row = 2;
          end else if (t == 8) begin
            col = 3; row = 2;
          end else begin
            col = t - 9; row = 3;
          end
        end
        default: ;
      endcase
      res.left   = strip_span(cur_width, n, 0, col);
      res.top    = strip_span(cur_height, n, 0, row);
      res.width  = strip_span(cur_width, n, col, cs);
      res.height = strip_span(cur_height, n, row, rs);
    end
    return res;
  endfunction

  // Frame dimension for a random phase: extremes, values near the split limit, ordinary sizes.
  function automatic logic [13:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 14'd0;
      1:       return 14'd8192;
      2:       return 14'h3FFF;
      3:       return 14'($urandom_range(0, 63));
      4:       return 14'($urandom);
      default: return 14'($urandom_range(64, 8192));
    endcase
  endfunction

  // Write one register once the block has drained; leave cfg_valid_i high for the caller to drop.
  task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
    while (pending_rects.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    case (idx)
      mlr_pkg::REG_FRAME_WIDTH:  cur_width  = data;
      mlr_pkg::REG_FRAME_HEIGHT: cur_height = data;
      mlr_pkg::REG_LAYOUT_CODE:  cur_layout = data[3:0];
      default: ;
    endcase
  endtask

  // Offer one query, wait for its handshake, record its rectangle, then maybe open a gap.
  task automatic send_query(input logic [4:0] tile, input logic fixed, input rect_t want);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, tile};
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    pending_rects.push_back(fixed ? want : tile_rect(tile));
    sent_cnt++;
    burst_left--;
    if (burst_left <= 0) begin
      // drop valid so that it is never lowered and raised in one step
      gap = $urandom_range(1, 12);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
    end
  endtask

  // Receiver: open stretches, random stalls, a periodic pattern and short full holds.
  always @(posedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode   = rdy_mode_e'($urandom_range(0, 3));
      rdy_left   = (rdy_mode == RDY_HOLD) ? $urandom_range(1, 40) : $urandom_range(16, 160);
      pat_period = $urandom_range(2, 9);
      pat_cnt    = 0;
    end else begin
      rdy_left--;
    end
    pat_cnt = (pat_cnt + 1) % pat_period;
    case (rdy_mode)
      RDY_OPEN:    m_axis_tready_i <= 1'b1;
      RDY_RANDOM:  m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      RDY_PATTERN: m_axis_tready_i <= (pat_cnt < pat_period / 2);
      default:     m_axis_tready_i <= 1'b0;
    endcase
  end

  // Check each accepted result against the oldest owed rectangle.
  always @(posedge clk_i) begin
    rect_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{m_axis_tdata_o[13:0], m_axis_tdata_o[27:14], m_axis_tdata_o[41:28],
              m_axis_tdata_o[55:42], mlr_pkg::status_e'(m_axis_tuser_o)};
      if (pending_rects.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result with no query pending: L=%0d T=%0d W=%0d H=%0d S=%0d",
                   $realtime, got.left, got.top, got.width, got.height, got.status);
      end else begin
        want = pending_rects.pop_front();
        if (got.left !== want.left || got.top !== want.top || got.width !== want.width ||
            got.height !== want.height || got.status !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: got L=%0d T=%0d W=%0d H=%0d S=%0d, want L=%0d T=%0d W=%0d H=%0d S=%0d",
                     $realtime, got.left, got.top, got.width, got.height, got.status,
                     want.left, want.top, want.width, want.height, want.status);
        end
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt == IDLE_LIMIT) begin
      $display("FAIL mosaic_layout_rectangles");
      $finish;
    end
  end

  initial begin
    int          k, r, mask, cnt;
    logic [4:0]  tile;
    logic [13:0] value;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows; hold cfg_valid_i across back-to-back writes.
    for (k = 0; k < DIR_ROWS; k++) begin
      if (DIR_TAB[k].kind == ROW_CFG) begin
        s_axis_tvalid_i <= 1'b0;
        write_reg(DIR_TAB[k].idx, DIR_TAB[k].data);
        if (k + 1 == DIR_ROWS || DIR_TAB[k + 1].kind != ROW_CFG)
          cfg_valid_i <= 1'b0;
      end else begin
        send_query(DIR_TAB[k].tile, DIR_TAB[k].fixed, DIR_TAB[k].want);
      end
    end

    // Random phases: a fresh subset of registers, then a run of mostly in-range queries.
    sent_cnt = 0;
    while (sent_cnt < RAND_ITEMS) begin
      s_axis_tvalid_i <= 1'b0;
      mask = $urandom_range(1, 15);
      for (r = 0; r < 4; r++) begin
        if (mask[r]) begin
          case (r)
            0: value = pick_dim();
            1: value = pick_dim();
            2: value = ($urandom_range(0, 7) == 0) ? 14'($urandom_range(10, 15)) |
                       (14'($urandom) & 14'h3FF0) : 14'($urandom_range(0, 9));
            default: value = 14'($urandom);
          endcase
          write_reg(2'(r), value);
          if ((mask >> (r + 1)) == 0)
            cfg_valid_i <= 1'b0;
        end
      end
      repeat ($urandom_range(10, 60)) begin
        cnt = tile_count(cur_layout);
        if (cnt > 0 && $urandom_range(0, 3) != 0)
          tile = 5'($urandom_range(0, cnt - 1));
        else
          tile = 5'($urandom);
        send_query(tile, 1'b0, RECT_NONE);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain: every owed rectangle back, then a wait for stray results.
    while (pending_rects.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_rects.size() == 0)
      $display("PASS mosaic_layout_rectangles");
    else
      $display("FAIL mosaic_layout_rectangles");
    $finish;
  end

endmodule
